// ===== rtl/rat_pkg.sv =====
// Shared types and constants for the rotor angle tracker.
`default_nettype none

package rat_pkg;

  localparam int unsigned ANGLE_W  = 16;
  localparam int unsigned POS_W    = 32;
  localparam int unsigned AGE_W    = 8;
  localparam int unsigned MULT_W   = 7;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 88;
  localparam int unsigned OUT_USER_W = 2;

  localparam logic [AGE_W-1:0] AGE_LIMIT = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ELEC_ZERO     = 3'd0,
    REG_ZERO_TRIM     = 3'd1,
    REG_ELEC_PER_MECH = 3'd2,
    REG_DIRECTION     = 3'd3,
    REG_MAX_AGE       = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [ANGLE_W-1:0]        elec_zero;
    logic signed [ANGLE_W-1:0] zero_trim;
    logic [MULT_W-1:0]         elec_per_mech;
    logic                      direction;
    logic [AGE_W-1:0]          max_age;
  } cfg_t;

  typedef struct packed {
    logic [ANGLE_W-1:0]        held_raw;
    logic [ANGLE_W-1:0]        electrical_angle;
    logic signed [ANGLE_W-1:0] step_delta;
    logic signed [POS_W-1:0]   turn_position;
    logic [AGE_W-1:0]          sample_age;
    logic                      angle_ok;
    logic                      angle_safe;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/rotor_angle_tracker.sv =====
// Top level of the rotor angle tracker: stream ports, config registers, pipeline registers.
// Path: a word accepted into the input register moves on into the result register, which drives out_tdata.
// Throughput: one word per cycle; the input register moves on whenever the result
// register is empty or being taken.
// Reset: synchronous, active low; clears both valid flags, tracking state
// (age to 255) and config registers to their defaults.
`default_nettype none

module rotor_angle_tracker (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [rat_pkg::IN_DATA_W-1:0]   in_tdata,  // raw_angle
  input  wire logic [rat_pkg::IN_USER_W-1:0]   in_tuser,  // update_ok, sensor_ok
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // held_raw, electrical_angle, step_delta, turn_position, sample_age
  output logic [rat_pkg::OUT_DATA_W-1:0]       out_tdata,
  output logic [rat_pkg::OUT_USER_W-1:0]       out_tuser, // angle_ok, angle_safe
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [rat_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [rat_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rat_pkg::*;

  cfg_t               cfg_r;
  logic               s1_valid_r;
  logic               s1_ok_r;
  logic [ANGLE_W-1:0] s1_raw_r;
  logic               out_valid_r;
  res_t               out_res_r;
  res_t               res;
  logic               adv;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.elec_zero     <= '0;
      cfg_r.zero_trim     <= '0;
      cfg_r.elec_per_mech <= MULT_W'(1);
      cfg_r.direction     <= 1'b1;
      cfg_r.max_age       <= AGE_W'(3);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ELEC_ZERO:     cfg_r.elec_zero     <= cfg_data[ANGLE_W-1:0];
        REG_ZERO_TRIM:     cfg_r.zero_trim     <= signed'(cfg_data[ANGLE_W-1:0]);
        REG_ELEC_PER_MECH: cfg_r.elec_per_mech <= cfg_data[MULT_W-1:0];
        REG_DIRECTION:     cfg_r.direction     <= cfg_data[0];
        REG_MAX_AGE:       cfg_r.max_age       <= cfg_data[AGE_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_ok_r  <= in_tuser[0] && in_tuser[1];
      s1_raw_r <= in_tdata[ANGLE_W-1:0];
    end
  end

  rat_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .ok    (s1_ok_r),
    .raw   (s1_raw_r),
    .cfg   (cfg_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.sample_age, out_res_r.turn_position,
                       out_res_r.step_delta, out_res_r.electrical_angle,
                       out_res_r.held_raw};
  assign out_tuser  = {out_res_r.angle_safe, out_res_r.angle_ok};

endmodule

`default_nettype wire

// ===== rtl/rat_core.sv =====
// Tracking state and per-sample update logic for the rotor angle tracker.
`default_nettype none

module rat_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         adv,
  input  wire logic                         ok,
  input  wire logic [rat_pkg::ANGLE_W-1:0]  raw,
  input  wire rat_pkg::cfg_t                cfg,
  output rat_pkg::res_t                     res
);
  import rat_pkg::*;

  logic [ANGLE_W-1:0]        last_raw_r, last_raw_nxt;
  logic [ANGLE_W-1:0]        prev_raw_r, prev_raw_nxt;
  logic [ANGLE_W-1:0]        last_elec_r, last_elec_nxt;
  logic signed [ANGLE_W-1:0] last_delta_r, last_delta_nxt;
  logic signed [POS_W-1:0]   pos_r, pos_nxt;
  logic [AGE_W-1:0]          age_r, age_nxt;
  logic                      started_r, started_nxt;

  logic [ANGLE_W-1:0]        base;
  logic [ANGLE_W+MULT_W-1:0] scaled;
  logic [ANGLE_W-1:0]        elec;
  logic [ANGLE_W-1:0]        delta;

  assign base   = cfg.elec_zero + ANGLE_W'(cfg.zero_trim);
  assign scaled = {{MULT_W{1'b0}}, raw} * {{ANGLE_W{1'b0}}, cfg.elec_per_mech};
  assign elec   = cfg.direction ? (base + scaled[ANGLE_W-1:0])
                                : (base - scaled[ANGLE_W-1:0]);
  assign delta  = raw - prev_raw_r;

  always_comb begin
    last_raw_nxt   = last_raw_r;
    prev_raw_nxt   = prev_raw_r;
    last_elec_nxt  = last_elec_r;
    last_delta_nxt = last_delta_r;
    pos_nxt        = pos_r;
    age_nxt        = age_r;
    started_nxt    = started_r;
    if (!ok) begin
      if (age_r != AGE_LIMIT) begin
        age_nxt = age_r + 1'b1;
      end
    end else begin
      last_raw_nxt  = raw;
      last_elec_nxt = elec;
      age_nxt       = '0;
      prev_raw_nxt  = raw;
      if (!started_r) begin
        last_delta_nxt = '0;
        started_nxt    = 1'b1;
      end else begin
        last_delta_nxt = delta;
        pos_nxt        = pos_r + POS_W'(signed'(delta));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_raw_r   <= '0;
      prev_raw_r   <= '0;
      last_elec_r  <= '0;
      last_delta_r <= '0;
      pos_r        <= '0;
      age_r        <= AGE_LIMIT;
      started_r    <= 1'b0;
    end else if (adv) begin
      last_raw_r   <= last_raw_nxt;
      prev_raw_r   <= prev_raw_nxt;
      last_elec_r  <= last_elec_nxt;
      last_delta_r <= last_delta_nxt;
      pos_r        <= pos_nxt;
      age_r        <= age_nxt;
      started_r    <= started_nxt;
    end
  end

  assign res.held_raw         = last_raw_nxt;
  assign res.electrical_angle = last_elec_nxt;
  assign res.step_delta       = last_delta_nxt;
  assign res.turn_position    = pos_nxt;
  assign res.sample_age       = age_nxt;
  assign res.angle_ok         = ok;
  assign res.angle_safe       = ok && (age_nxt <= cfg.max_age);

endmodule

`default_nettype wire

// ===== rtl/rat_checker.sv =====
// Port-level checks for the rotor angle tracker and their bind.
`default_nettype none

module rat_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tready,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [rat_pkg::OUT_DATA_W-1:0]  out_tdata,
  input wire logic [rat_pkg::OUT_USER_W-1:0]  out_tuser
);
  import rat_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  a_safe_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tuser[0])
    else $error("angle_safe without angle_ok");

  a_ok_clears_age: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[87:80] == 8'd0)
    else $error("valid sample did not clear the age");

  a_in_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid || out_tready |-> in_tready)
    else $error("input stalled while result side was free");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind rotor_angle_tracker rat_checker u_rat_checker (.*);

`default_nettype wire
